// ===== src/f32f16_pkg.sv =====
// ----------------------------------------------------------------------------
// f32f16_pkg
// shared constants and types of the single/half float converter
// ----------------------------------------------------------------------------
`default_nettype none
package f32f16_pkg;

  // conversion direction
  typedef enum logic {
    MODE_S2H = 1'b0,
    MODE_H2S = 1'b1
  } mode_t;

  localparam logic [31:0] SGL_INF     = 32'h7F80_0000;
  localparam logic [31:0] SGL_HMAX    = 32'h477F_E000;
  localparam logic [31:0] SGL_HMIN    = 32'h3880_0000;
  localparam logic [31:0] SGL_NANMIN  = 32'h7F80_2000;
  localparam int          DROP_BITS   = 13;
  localparam logic [18:0] MAXC        = 19'(SGL_HMAX >> DROP_BITS);
  localparam logic [18:0] REBIAS      = 19'h1C000;
  localparam logic [18:0] HALF_SUBMAX = 19'h003FF;

endpackage
`default_nettype wire

// ===== src/f32f16_s2h.sv =====
// ----------------------------------------------------------------------------
// f32f16_s2h
// single to half conversion, combinational, mantissa truncated
// ----------------------------------------------------------------------------
`default_nettype none
module f32f16_s2h
  import f32f16_pkg::*;
(
  input  wire logic [31:0] operand,
  output logic      [15:0] half
);

  logic [30:0] mag;
  logic [7:0]  e;
  logic [23:0] m;
  logic [7:0]  sh;
  logic [30:0] v;
  logic [18:0] t;
  logic [18:0] t1;
  logic [18:0] t2;

  always_comb begin
    mag = operand[30:0];
    e   = mag[30:23];
    m   = {1'b1, mag[22:0]};
    sh  = 8'd113 - e;
    // clamp special ranges before dropping the low bits
    if ({1'b0, mag} < SGL_HMIN) begin
      if (e == 8'd0 || sh >= 8'd32) v = '0;
      else v = 31'({7'd0, m} >> sh[4:0]);
    end else if ({1'b0, mag} > SGL_HMAX && {1'b0, mag} < SGL_INF) begin
      v = SGL_INF[30:0];
    end else if ({1'b0, mag} > SGL_INF && {1'b0, mag} < SGL_NANMIN) begin
      v = SGL_NANMIN[30:0];
    end else begin
      v = mag;
    end
    // rebias exponent
    t  = {1'b0, v[30:13]};
    t1 = (t > MAXC) ? t - REBIAS : t;
    t2 = (t1 > HALF_SUBMAX) ? t1 - REBIAS : t1;
    half = {operand[31], t2[14:0]};
  end

endmodule
`default_nettype wire

// ===== src/f32f16_h2s.sv =====
// ----------------------------------------------------------------------------
// f32f16_h2s
// half to single conversion, exact, subnormals normalised
// ----------------------------------------------------------------------------
`default_nettype none
module f32f16_h2s
  import f32f16_pkg::*;
(
  input  wire logic [15:0] half,
  output logic      [31:0] single
);

  logic [14:0] v;
  logic [3:0]  p;
  logic [18:0] t;
  logic [22:0] frac;

  always_comb begin
    v = half[14:0];
    p = 4'd0;
    // leading one position of a subnormal mantissa
    for (int i = 0; i < 10; i++) begin
      if (v[i]) p = 4'(i);
    end
    frac = 23'({13'd0, v[9:0]} << (5'd23 - {1'b0, p}));
    t = {4'd0, v} + REBIAS;
    if (t > MAXC) t = t + REBIAS;
    if (v == 15'd0) begin
      single = {half[15], 31'd0};
    end else if (v[14:10] == 5'd0) begin
      single = {half[15], 8'({4'd0, p} + 8'd103), frac};
    end else begin
      single = {half[15], t[17:0], 13'd0};
    end
  end

endmodule
`default_nettype wire

// ===== src/float32_float16_converter_top.sv =====
// ----------------------------------------------------------------------------
// float32_float16_converter_top
// single/half float bit-pattern converter, direction chosen per item
// ----------------------------------------------------------------------------
// result path: the start transfer passes the input register, then the result register, which raises done
// throughput: one item per cycle, busy is always low
// one input register and one result register lie around the converters
// reset clears the valid pipeline; no results are lost as the receiver never stalls
`default_nettype none
module float32_float16_converter_top
  import f32f16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [31:0] operand_bits,
  output logic             done,
  output logic      [31:0] result_bits
);

  logic        in_valid;
  mode_t       in_mode;
  logic [31:0] in_operand;
  logic [15:0] half;
  logic [31:0] single;
  logic [31:0] result_next;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else in_valid <= start;
    in_mode    <= mode_t'(mode);
    in_operand <= operand_bits;
  end

  f32f16_s2h u_s2h (.operand(in_operand), .half(half));
  f32f16_h2s u_h2s (.half(in_operand[15:0]), .single(single));

  assign result_next = (in_mode == MODE_H2S) ? single : {16'd0, half};

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= in_valid;
    result_bits <= result_next;
  end

`ifndef SYNTHESIS
  a_done_follows : assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done) else $error("done did not follow accepted item");
  a_half_upper : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_mode == MODE_S2H |=> result_bits[31:16] == 16'd0)
    else $error("half result has upper bits set");
  a_start_two : assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done) else $error("missing result two cycles after start");
`endif

endmodule
`default_nettype wire
